@@ hdl/mtg_pkg.sv @@
package mtg_pkg;

  // build-time sizing
  localparam int MAX_CHANNELS = 64;
  localparam int OFFSET_SLOTS = 64;

  // field widths
  localparam int INIT_W   = 8;
  localparam int CNT_W    = 7;
  localparam int STRIDE_W = 33;
  localparam int PAY_W    = 13;
  localparam int LIMIT_W  = 16;
  localparam int OP_W     = 2;
  localparam int LAT_W    = 32;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int TALLY_W  = 16;
  localparam int BYTES_W  = 32;
  localparam int SUM_W    = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  // derived widths
  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SLOT_W  = (OFFSET_SLOTS > 1) ? $clog2(OFFSET_SLOTS) : 1;
  localparam int DIV_W   = $clog2(255 + MAX_CHANNELS);
  localparam int STEP_W  = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIATOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;

  // register reset values
  localparam logic [INIT_W-1:0]   RST_INITIATOR = '0;
  localparam logic [CNT_W-1:0]    RST_CHANNELS  = 7'd4;
  localparam logic [STRIDE_W-1:0] RST_STRIDE    = 33'h0_4000_0000;
  localparam logic [PAY_W-1:0]    RST_PAYLOAD   = 13'd64;
  localparam logic [LIMIT_W-1:0]  RST_LIMIT     = 16'd500;

  // operation codes
  localparam logic [OP_W-1:0] OP_ISSUE      = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_DONE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_DONE  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  typedef struct packed {
    logic              start_mod;
    logic              step_mod;
    logic              capture;
    logic              advance;
    logic              rec_write;
    logic              rec_read;
    logic              load_out;
    logic [KIND_W-1:0] out_kind;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [DATA_W-1:0]  data_word;
    logic               last;
    logic               done_res;
    logic [TALLY_W-1:0] write_count;
    logic [TALLY_W-1:0] read_count;
    logic [BYTES_W-1:0] byte_total;
    logic [SUM_W-1:0]   latency_sum;
    logic [LAT_W-1:0]   latency_min;
    logic [LAT_W-1:0]   latency_max;
  } result_t;

endpackage

@@ hdl/mtg_cfg_if.sv @@
interface mtg_cfg_if import mtg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/mtg_item_if.sv @@
interface mtg_item_if import mtg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [LAT_W-1:0] latency;

  modport source (output valid, operation, latency, input ready);
  modport sink (input valid, operation, latency, output ready);
endinterface

@@ hdl/mtg_result_if.sv @@
interface mtg_result_if import mtg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ADDR_W-1:0]  address;
  logic [DATA_W-1:0]  data_word;
  logic               last;
  logic               done_res;
  logic [TALLY_W-1:0] write_count;
  logic [TALLY_W-1:0] read_count;
  logic [BYTES_W-1:0] byte_total;
  logic [SUM_W-1:0]   latency_sum;
  logic [LAT_W-1:0]   latency_min;
  logic [LAT_W-1:0]   latency_max;

  modport source (
    output valid, kind, address, data_word, last, done_res, write_count, read_count,
           byte_total, latency_sum, latency_min, latency_max,
    input  ready
  );
  modport sink (
    input  valid, kind, address, data_word, last, done_res, write_count, read_count,
           byte_total, latency_sum, latency_min, latency_max,
    output ready
  );
endinterface

@@ hdl/mtg_datapath.sv @@
module mtg_datapath import mtg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  input  logic [LAT_W-1:0]      latency_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output result_t               result_o
);

  // configuration
  logic [INIT_W-1:0]   init_q;
  logic [CNT_W-1:0]    chan_cnt_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [PAY_W-1:0]    payload_q;
  logic [LIMIT_W-1:0]  limit_q;

  // generator and statistics state
  logic [CH_W-1:0]    chan_idx_q;
  logic [LIMIT_W-1:0] pair_cnt_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TALLY_W-1:0] writes_q;
  logic [TALLY_W-1:0] reads_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [SUM_W-1:0]   lat_sum_q;
  logic [LAT_W-1:0]   lat_min_q;
  logic [LAT_W-1:0]   lat_max_q;

  // serial remainder lanes: a = channel offset, b = next channel index
  logic [CNT_W-1:0] n_q;
  logic [DIV_W-1:0] dvd_a_q, dvd_b_q;
  logic [CNT_W-1:0] rem_a_q, rem_b_q;

  logic [ADDR_W-1:0]       prod_a_q;
  logic [SLOT_W+PAY_W-1:0] prod_b_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [DATA_W-1:0]       data_q;
  result_t                 res_q;

  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W+ADDR_W-1:0] prod_a_full;
  logic [SLOT_W+PAY_W-1:0] prod_b_full;
  logic [SUM_W:0]          lat_sum_full;
  logic [SUM_W-1:0]        lat_sum_sat;
  logic                    rec;

  function automatic logic [CNT_W-1:0] mod_step(input logic [CNT_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] sh;
    sh = {rem, bit_in};
    if (sh >= {1'b0, n}) begin
      mod_step = CNT_W'(sh - {1'b0, n});
    end else begin
      mod_step = sh[CNT_W-1:0];
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (chan_cnt_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(chan_cnt_q) > MAX_CHANNELS) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = chan_cnt_q;
    end
  end

  assign prod_a_full  = (CNT_W+ADDR_W)'(rem_a_q) * (CNT_W+ADDR_W)'(stride_q[ADDR_W-1:0]);
  assign prod_b_full  = (SLOT_W+PAY_W)'(slot_q) * (SLOT_W+PAY_W)'(payload_q);
  assign lat_sum_full = {1'b0, lat_sum_q} + (SUM_W+1)'(latency_i);
  assign lat_sum_sat  = lat_sum_full[SUM_W] ? '1 : lat_sum_full[SUM_W-1:0];
  assign rec          = cmd_i.rec_write | cmd_i.rec_read;

  assign status_o.limit_hit = (pair_cnt_q >= limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= RST_INITIATOR;
      chan_cnt_q <= RST_CHANNELS;
      stride_q   <= RST_STRIDE;
      payload_q  <= RST_PAYLOAD;
      limit_q    <= RST_LIMIT;
      chan_idx_q <= '0;
      pair_cnt_q <= '0;
      slot_q     <= '0;
      writes_q   <= '0;
      reads_q    <= '0;
      bytes_q    <= '0;
      lat_sum_q  <= '0;
      lat_min_q  <= '1;
      lat_max_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_INITIATOR: init_q     <= cfg_data_i[INIT_W-1:0];
          CFG_CHANNELS:  chan_cnt_q <= cfg_data_i[CNT_W-1:0];
          CFG_STRIDE:    stride_q   <= cfg_data_i[STRIDE_W-1:0];
          CFG_PAYLOAD:   payload_q  <= cfg_data_i[PAY_W-1:0];
          CFG_LIMIT:     limit_q    <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.advance) begin
        chan_idx_q <= CH_W'(rem_b_q);
        pair_cnt_q <= pair_cnt_q + LIMIT_W'(1);
        if (slot_q == SLOT_W'(OFFSET_SLOTS - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + SLOT_W'(1);
        end
      end
      if (cmd_i.rec_write) begin
        writes_q <= writes_q + TALLY_W'(1);
      end
      if (cmd_i.rec_read) begin
        reads_q <= reads_q + TALLY_W'(1);
      end
      if (rec) begin
        bytes_q   <= bytes_q + BYTES_W'(payload_q);
        lat_sum_q <= lat_sum_sat;
        if (latency_i < lat_min_q) begin
          lat_min_q <= latency_i;
        end
        if (latency_i > lat_max_q) begin
          lat_max_q <= latency_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_mod) begin
      n_q     <= n_eff;
      dvd_a_q <= DIV_W'(init_q) + DIV_W'(chan_idx_q);
      dvd_b_q <= DIV_W'(chan_idx_q) + DIV_W'(1);
      rem_a_q <= '0;
      rem_b_q <= '0;
    end else if (cmd_i.step_mod) begin
      rem_a_q <= mod_step(rem_a_q, dvd_a_q[DIV_W-1], n_q);
      rem_b_q <= mod_step(rem_b_q, dvd_b_q[DIV_W-1], n_q);
      dvd_a_q <= dvd_a_q << 1;
      dvd_b_q <= dvd_b_q << 1;
    end
    if (cmd_i.capture) begin
      prod_a_q <= prod_a_full[ADDR_W-1:0];
      prod_b_q <= prod_b_full;
      // tag uses the channel and pair count of this pair, before they advance
      data_q   <= {init_q, 8'(chan_idx_q), pair_cnt_q};
    end
    if (cmd_i.advance) begin
      addr_q <= prod_a_q + ADDR_W'(prod_b_q);
    end
    if (cmd_i.load_out) begin
      res_q.kind        <= cmd_i.out_kind;
      res_q.last        <= cmd_i.out_last;
      res_q.address     <= (cmd_i.out_kind == KIND_REPORT) ? '0 : addr_q;
      res_q.data_word   <= (cmd_i.out_kind == KIND_REPORT) ? '0 : data_q;
      res_q.done_res    <= (pair_cnt_q >= limit_q);
      res_q.write_count <= writes_q;
      res_q.read_count  <= reads_q;
      res_q.byte_total  <= bytes_q;
      res_q.latency_sum <= lat_sum_q;
      res_q.latency_min <= lat_min_q;
      res_q.latency_max <= lat_max_q;
    end
  end

  assign result_o = res_q;

endmodule

@@ hdl/mtg_ctrl.sv @@
module mtg_ctrl import mtg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  logic [OP_W-1:0] item_operation_i,
  output logic            item_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  status_t         status_i,
  output cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_MUL,
    S_ADD,
    S_EMIT_WR,
    S_EMIT_RD,
    S_REPORT
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free     = ~out_valid_q | out_ready_i;
  assign item_ready_o = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          case (item_operation_i)
            OP_ISSUE: begin
              // past the limit an issue tick is dropped
              if (!status_i.limit_hit) begin
                cmd_o.start_mod = 1'b1;
                step_d          = '0;
                state_d         = S_MOD;
              end
            end
            OP_WRITE_DONE: begin
              cmd_o.rec_write = 1'b1;
              state_d         = S_REPORT;
            end
            OP_READ_DONE: begin
              cmd_o.rec_read = 1'b1;
              state_d        = S_REPORT;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        cmd_o.step_mod = 1'b1;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          state_d = S_MUL;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_MUL: begin
        cmd_o.capture = 1'b1;
        state_d       = S_ADD;
      end
      S_ADD: begin
        cmd_o.advance = 1'b1;
        state_d       = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = KIND_WRITE;
          cmd_o.out_last = 1'b0;
          out_valid_d    = 1'b1;
          state_d        = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = KIND_READ;
          cmd_o.out_last = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = KIND_REPORT;
          cmd_o.out_last = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/mem_traffic_generator.sv @@
// Memory traffic generator. An issue tick on item_i produces a write request and then
// a read request to the same address on result_o; the address is the rotating channel's
// base (channel times stride) plus the pair count's slot times the payload size. Write
// and read completion items update the statistics and answer with one report; every
// result carries the current statistics. After the pair limit is reached issue ticks
// are dropped without a result, as is operation code 3. An issue tick passes through
// a 9-step bit-serial remainder unit (channel select modulo the channel count),
// a multiply, an address add and two output loads, which wait while result_o is
// stalled; a new item is accepted only once the block is back in idle. Configuration
// is always ready and is to be written only while the block is idle.
module mem_traffic_generator import mtg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mtg_cfg_if.sink      cfg_i,
  mtg_item_if.sink     item_i,
  mtg_result_if.source result_o
);

  cmd_t    cmd;
  status_t status;
  result_t res;
  logic    cfg_ready;
  logic    item_ready;
  logic    out_valid;

  mtg_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_i.valid),
    .item_operation_i (item_i.operation),
    .item_ready_o     (item_ready),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (out_valid),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  mtg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_ready),
    .latency_i   (item_i.latency),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (res)
  );

  assign cfg_i.ready          = cfg_ready;
  assign item_i.ready         = item_ready;
  assign result_o.valid       = out_valid;
  assign result_o.kind        = res.kind;
  assign result_o.address     = res.address;
  assign result_o.data_word   = res.data_word;
  assign result_o.last        = res.last;
  assign result_o.done_res    = res.done_res;
  assign result_o.write_count = res.write_count;
  assign result_o.read_count  = res.read_count;
  assign result_o.byte_total  = res.byte_total;
  assign result_o.latency_sum = res.latency_sum;
  assign result_o.latency_min = res.latency_min;
  assign result_o.latency_max = res.latency_max;

endmodule

@@ verif/tb_mem_traffic_generator.sv @@
module tb_mem_traffic_generator;
  import mtg_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int STALL_MAX     = 17;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 512;
  localparam int PHASES        = 8;
  localparam int BURST_ITEMS   = 16;
  localparam int PRINT_CAP     = 100;

  class traffic_scoreboard;
    logic [INIT_W-1:0]   initiator;
    logic [CNT_W-1:0]    channels;
    logic [STRIDE_W-1:0] stride;
    logic [PAY_W-1:0]    payload;
    logic [LIMIT_W-1:0]  pair_limit;
    logic [CH_W-1:0]     channel;
    logic [LIMIT_W-1:0]  pairs;
    logic [TALLY_W-1:0]  writes;
    logic [TALLY_W-1:0]  reads;
    logic [BYTES_W-1:0]  bytes;
    logic [SUM_W-1:0]    lat_sum;
    logic [LAT_W-1:0]    lat_min;
    logic [LAT_W-1:0]    lat_max;
    result_t             due_results[$];
    int                  mismatches;

    function new();
      initiator  = RST_INITIATOR;
      channels   = RST_CHANNELS;
      stride     = RST_STRIDE;
      payload    = RST_PAYLOAD;
      pair_limit = RST_LIMIT;
      channel    = '0;
      pairs      = '0;
      writes     = '0;
      reads      = '0;
      bytes      = '0;
      lat_sum    = '0;
      lat_min    = '1;
      lat_max    = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_INITIATOR: initiator  = value[INIT_W-1:0];
        CFG_CHANNELS:  channels   = value[CNT_W-1:0];
        CFG_STRIDE:    stride     = value[STRIDE_W-1:0];
        CFG_PAYLOAD:   payload    = value[PAY_W-1:0];
        CFG_LIMIT:     pair_limit = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void queue_result(result_t r);
      due_results.insert(due_results.size(), r);
    endfunction

    // every result carries the statistics as they stand after the item
    function result_t stats_result(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                   logic [DATA_W-1:0] data, logic last);
      result_t r;
      r.kind        = kind;
      r.address     = addr;
      r.data_word   = data;
      r.last        = last;
      r.done_res    = (pairs >= pair_limit);
      r.write_count = writes;
      r.read_count  = reads;
      r.byte_total  = bytes;
      r.latency_sum = lat_sum;
      r.latency_min = lat_min;
      r.latency_max = lat_max;
      return r;
    endfunction

    function void tally_completion(logic [LAT_W-1:0] lat);
      logic [SUM_W:0] sum;
      bytes = bytes + payload;
      sum = {1'b0, lat_sum} + lat;
      lat_sum = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
      if (lat < lat_min) lat_min = lat;
      if (lat > lat_max) lat_max = lat;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [LAT_W-1:0] lat);
      int unsigned n;
      int unsigned eff;
      logic [63:0] span;
      logic [DATA_W-1:0] data;
      case (op)
        OP_ISSUE: begin
          if (pairs >= pair_limit) return;
          n = (channels == 0) ? 1 : (channels > MAX_CHANNELS) ? MAX_CHANNELS : channels;
          // a channel left over from a larger count is folded by the modulo
          eff = (initiator + channel) % n;
          span = 64'(eff) * 64'(stride) + 64'(pairs % OFFSET_SLOTS) * 64'(payload);
          data = (DATA_W'(initiator) << 24) | (DATA_W'(channel) << 16) | DATA_W'(pairs);
          channel = CH_W'((channel + 1) % n);
          pairs = pairs + 1'b1;
          queue_result(stats_result(KIND_WRITE, span[ADDR_W-1:0], data, 1'b0));
          queue_result(stats_result(KIND_READ, span[ADDR_W-1:0], data, 1'b1));
        end
        OP_WRITE_DONE: begin
          writes = writes + 1'b1;
          tally_completion(lat);
          queue_result(stats_result(KIND_REPORT, '0, '0, 1'b1));
        end
        OP_READ_DONE: begin
          reads = reads + 1'b1;
          tally_completion(lat);
          queue_result(stats_result(KIND_REPORT, '0, '0, 1'b1));
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $error("%s: expected %0h, actual %0h", field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $error("result with no item pending: kind %0h, expected none", got.kind);
        return;
      end
      want = due_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("address", want.address, got.address);
      compare("data_word", want.data_word, got.data_word);
      compare("last", want.last, got.last);
      compare("done_res", want.done_res, got.done_res);
      compare("write_count", want.write_count, got.write_count);
      compare("read_count", want.read_count, got.read_count);
      compare("byte_total", want.byte_total, got.byte_total);
      compare("latency_sum", want.latency_sum, got.latency_sum);
      compare("latency_min", want.latency_min, got.latency_min);
      compare("latency_max", want.latency_max, got.latency_max);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mtg_cfg_if    cfg_bus ();
  mtg_item_if   item_bus ();
  mtg_result_if res_bus ();

  mem_traffic_generator i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (res_bus)
  );

  traffic_scoreboard sb = new();

  int src_run     = 0;
  int sink_run    = 0;
  bit steady_src  = 1'b0;
  bit steady_sink = 1'b0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // uniform gaps, broken up now and then by a run of back-to-back items
  function automatic int draw_gap(ref int run_left, input bit steady);
    if (steady) return 0;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left = $urandom_range(8, 40);
    return $urandom_range(0, STALL_MAX);
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [LAT_W-1:0] lat);
    int gap;
    gap = draw_gap(src_run, steady_src);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.operation <= op;
    item_bus.latency   <= lat;
    do begin
      @(posedge clk);
    end while (!item_bus.ready);
    sb.note_item(op, lat);
  endtask

  // let every pending result drain, then give dropped items time to finish
  task automatic settle(int extra);
    item_bus.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.outstanding() > 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_bus.ready);
    sb.load_reg(idx, value);
  endtask

  task automatic write_regs(logic [INIT_W-1:0] init, logic [CNT_W-1:0] cnt,
                            logic [STRIDE_W-1:0] stride, logic [PAY_W-1:0] pay,
                            logic [LIMIT_W-1:0] lim);
    put_reg(CFG_INITIATOR, CFG_DATA_W'(init));
    put_reg(CFG_CHANNELS, CFG_DATA_W'(cnt));
    put_reg(CFG_STRIDE, CFG_DATA_W'(stride));
    put_reg(CFG_PAYLOAD, CFG_DATA_W'(pay));
    put_reg(CFG_LIMIT, CFG_DATA_W'(lim));
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : result_sink
    result_t got;
    int gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(sink_run, steady_sink);
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!res_bus.valid);
      got.kind        = res_bus.kind;
      got.address     = res_bus.address;
      got.data_word   = res_bus.data_word;
      got.last        = res_bus.last;
      got.done_res    = res_bus.done_res;
      got.write_count = res_bus.write_count;
      got.read_count  = res_bus.read_count;
      got.byte_total  = res_bus.byte_total;
      got.latency_sum = res_bus.latency_sum;
      got.latency_min = res_bus.latency_min;
      got.latency_max = res_bus.latency_max;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[mem_traffic_generator] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int counted;
    int roll;
    logic [OP_W-1:0]     op;
    logic [LAT_W-1:0]    lat;
    logic [INIT_W-1:0]   init;
    logic [CNT_W-1:0]    cnt;
    logic [STRIDE_W-1:0] stride;
    logic [PAY_W-1:0]    pay;
    logic [LIMIT_W-1:0]  lim;

    rst_n              = 1'b0;
    item_bus.valid     = 1'b0;
    item_bus.operation = OP_ISSUE;
    item_bus.latency   = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_INITIATOR;
    cfg_bus.data       = '0;
    res_bus.ready      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values straight out of reset
    send_item(OP_ISSUE, '0);
    send_item(OP_WRITE_DONE, '0);
    send_item(OP_READ_DONE, '1);
    send_item(OP_UNUSED, 32'hDEAD_BEEF);
    send_item(OP_ISSUE, '1);
    send_item(OP_ISSUE, $urandom);
    settle(SETTLE_CYCLES);

    // zero channels acts as one, current channel is now beyond the count
    write_regs('1, 7'd0, '1, '1, sb.pairs + 2'd2);
    send_item(OP_ISSUE, $urandom);
    send_item(OP_ISSUE, $urandom);
    send_item(OP_ISSUE, $urandom);
    send_item(OP_WRITE_DONE, '1);
    send_item(OP_READ_DONE, '0);
    send_item(OP_UNUSED, '1);
    settle(SETTLE_CYCLES);

    // limit of zero: every issue dropped; count above the maximum
    write_regs('0, 7'd127, '0, '0, '0);
    send_item(OP_ISSUE, '0);
    send_item(OP_WRITE_DONE, 32'd1);
    settle(SETTLE_CYCLES);

    write_regs(8'hA5, 7'd64, 33'h1_0000_0000, 13'd4096, sb.pairs + 16'd3);
    send_item(OP_ISSUE, $urandom);
    send_item(OP_ISSUE, $urandom);
    send_item(OP_READ_DONE, 32'h8000_0000);
    send_item(OP_ISSUE, $urandom);
    settle(SETTLE_CYCLES);

    for (phase = 0; phase < PHASES; phase++) begin
      init = INIT_W'($urandom_range(0, 255));
      cnt = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                                                 $urandom_range(1, 64));
      case ($urandom_range(0, 3))
        0: stride = '0;
        1: stride = '1;
        default: stride = {1'($urandom_range(0, 1)), 32'($urandom)};
      endcase
      case ($urandom_range(0, 3))
        0: pay = 13'd4;
        1: pay = 13'd4096;
        default: pay = PAY_W'($urandom_range(0, 8191));
      endcase
      if (phase == PHASES - 1) lim = '1;
      else if ($urandom_range(0, 7) == 0) lim = sb.pairs >> 1;
      else lim = sb.pairs + 16'($urandom_range(30, 90));
      write_regs(init, cnt, stride, pay, lim);

      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) begin
        roll = $urandom_range(0, 19);
        if (roll < 12) op = OP_ISSUE;
        else if (roll < 16) op = OP_WRITE_DONE;
        else if (roll < 19) op = OP_READ_DONE;
        else op = OP_UNUSED;
        case ($urandom_range(0, 9))
          0: lat = '0;
          1: lat = '1;
          default: lat = $urandom;
        endcase
        counted++;
        send_item(op, lat);
        if ($urandom_range(0, 49) == 0) settle(0);
      end
      settle(SETTLE_CYCLES);
    end

    // back-to-back completions with no gaps on either side
    write_regs(INIT_W'($urandom_range(0, 255)), 7'd4, STRIDE_W'($urandom), 13'd4096,
               sb.pairs + 16'd4);
    steady_src  = 1'b1;
    steady_sink = 1'b1;
    repeat (BURST_ITEMS) send_item(OP_WRITE_DONE, '1);
    steady_src  = 1'b0;
    steady_sink = 1'b0;
    send_item(OP_READ_DONE, $urandom);
    send_item(OP_ISSUE, $urandom);
    send_item(OP_WRITE_DONE, '0);
    send_item(OP_ISSUE, $urandom);
    settle(SETTLE_CYCLES);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[mem_traffic_generator] OK");
    end else begin
      $display("[mem_traffic_generator] ERROR");
    end
    $finish;
  end

endmodule
